FILE: rtl/tsep_pkg.sv
// ----------------------------------------------------------------------------
// tsep_pkg: shared types and constants of the timed sound event player
// Item formats, action codes, queue depths and output amplitudes.
// ----------------------------------------------------------------------------
package tsep_pkg;

    // Event queue depths and derived widths
    localparam int SPK_DEPTH = 1024;
    localparam int DAC_DEPTH = 2048;
    localparam int SPK_AW    = $clog2(SPK_DEPTH);
    localparam int SPK_CW    = $clog2(SPK_DEPTH + 1);
    localparam int DAC_AW    = $clog2(DAC_DEPTH);
    localparam int DAC_CW    = $clog2(DAC_DEPTH + 1);

    // Command queue between front and back
    localparam int CQ_DEPTH  = 4;
    localparam int CQ_AW     = $clog2(CQ_DEPTH);
    localparam int CQ_CW     = $clog2(CQ_DEPTH + 1);

    // Action codes of an input item
    localparam logic [1:0] ACT_SPK_PUSH = 2'd0;
    localparam logic [1:0] ACT_DAC_PUSH = 2'd1;
    localparam logic [1:0] ACT_TICK     = 2'd2;

    // Output levels
    localparam logic signed [15:0] SPK_HIGH = 16'sh7fff;
    localparam logic signed [15:0] SPK_LOW  = 16'sh8001;
    localparam logic [7:0]         DAC_BIAS = 8'h80;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  sample_byte;
        logic [31:0] event_time;
    } in_item_t;

    typedef struct packed {
        logic               accepted;
        logic signed [15:0] audio_sample;
        logic               is_audio;
    } res_item_t;

    typedef enum logic [1:0] {
        CMD_SPK_PUSH,
        CMD_DAC_PUSH,
        CMD_TICK,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  sample;
        logic [31:0] stamp;
    } cmd_t;

    // Status from the command queue to its two sides
    typedef struct packed {
        logic full;
        logic valid;
    } cq_status_t;

endpackage

FILE: rtl/tsep_fifo.sv
// ----------------------------------------------------------------------------
// tsep_fifo: command queue
// Short queue of classified commands between the front and the back end.
// ----------------------------------------------------------------------------
module tsep_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tsep_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output tsep_pkg::cmd_t      head_cmd,
    output tsep_pkg::cq_status_t status
);

    tsep_pkg::cmd_t               slot_reg [tsep_pkg::CQ_DEPTH];
    logic [tsep_pkg::CQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tsep_pkg::CQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tsep_pkg::CQ_CW-1:0]   count_reg, count_next;
    logic                         do_push, do_pop;

    assign status.full  = (count_reg == tsep_pkg::CQ_CW'(tsep_pkg::CQ_DEPTH));
    assign status.valid = (count_reg != '0);
    assign head_cmd     = slot_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && status.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == tsep_pkg::CQ_AW'(tsep_pkg::CQ_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tsep_pkg::CQ_AW'(tsep_pkg::CQ_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/tsep_front.sv
// ----------------------------------------------------------------------------
// tsep_front: item intake
// Registers each accepted item, classifies its action and feeds the queue.
// ----------------------------------------------------------------------------
module tsep_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  tsep_pkg::in_item_t   cmd_item,
    input  tsep_pkg::cq_status_t cq_status,
    output logic                 push,
    output tsep_pkg::cmd_t       push_cmd
);

    logic                valid_reg, valid_next;
    tsep_pkg::cmd_t      cmd_reg, cmd_next;
    logic                take;
    tsep_pkg::cmd_kind_t kind;

    assign cmd_stall = valid_reg && cq_status.full;
    assign take      = cmd_valid && !cmd_stall;
    assign push      = valid_reg && !cq_status.full;
    assign push_cmd  = cmd_reg;

    always_comb
    begin
        unique case (cmd_item.action)
            tsep_pkg::ACT_SPK_PUSH: kind = tsep_pkg::CMD_SPK_PUSH;
            tsep_pkg::ACT_DAC_PUSH: kind = tsep_pkg::CMD_DAC_PUSH;
            tsep_pkg::ACT_TICK:     kind = tsep_pkg::CMD_TICK;
            default:                kind = tsep_pkg::CMD_NOP;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg && cq_status.full;
        cmd_next   = cmd_reg;
        if (take)
        begin
            valid_next     = 1'b1;
            cmd_next.kind  = kind;
            cmd_next.sample = cmd_item.sample_byte;
            cmd_next.stamp  = cmd_item.event_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

FILE: rtl/tsep_back.sv
// ----------------------------------------------------------------------------
// tsep_back: event engine
// Holds both event rings, stores pushes, drains due events of the ring
// chosen by the mode on a tick and drives the result register.
// ----------------------------------------------------------------------------
module tsep_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsep_pkg::cq_status_t cq_status,
    input  tsep_pkg::cmd_t       head_cmd,
    output logic                 pop,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output tsep_pkg::res_item_t  res_item
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic                          mode_reg, mode_next;
    logic [tsep_pkg::SPK_AW-1:0]   spk_head_reg, spk_head_next;
    logic [tsep_pkg::SPK_AW-1:0]   spk_tail_reg, spk_tail_next;
    logic [tsep_pkg::SPK_CW-1:0]   spk_count_reg, spk_count_next;
    logic [tsep_pkg::DAC_AW-1:0]   dac_head_reg, dac_head_next;
    logic [tsep_pkg::DAC_AW-1:0]   dac_tail_reg, dac_tail_next;
    logic [tsep_pkg::DAC_CW-1:0]   dac_count_reg, dac_count_next;
    logic [31:0]                   tick_reg, tick_next;
    logic [7:0]                    dac_hold_reg, dac_hold_next;
    tsep_pkg::res_item_t           pend_reg, pend_next;
    logic                          res_valid_reg, res_valid_next;
    tsep_pkg::res_item_t           res_item_reg, res_item_next;

    logic [31:0] spk_mem [tsep_pkg::SPK_DEPTH];
    logic [31:0] dac_time_mem [tsep_pkg::DAC_DEPTH];
    logic [7:0]  dac_smp_mem [tsep_pkg::DAC_DEPTH];
    logic [31:0] spk_rd_reg;
    logic [31:0] dac_time_rd_reg;
    logic [7:0]  dac_smp_rd_reg;

    logic spk_we, dac_we;
    logic spk_full, dac_full;
    logic spk_due, dac_due;
    logic [7:0] dac_level;

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    assign spk_full = (spk_count_reg == tsep_pkg::SPK_CW'(tsep_pkg::SPK_DEPTH));
    assign dac_full = (dac_count_reg == tsep_pkg::DAC_CW'(tsep_pkg::DAC_DEPTH));
    assign spk_due  = (spk_count_reg != '0) && (tick_reg >= spk_rd_reg);
    assign dac_due  = (dac_count_reg != '0) && (tick_reg >= dac_time_rd_reg);
    assign dac_level = dac_hold_reg ^ tsep_pkg::DAC_BIAS;

    assign pop    = (state_reg == ST_IDLE) && cq_status.valid;
    assign spk_we = pop && (head_cmd.kind == tsep_pkg::CMD_SPK_PUSH) && !spk_full;
    assign dac_we = pop && (head_cmd.kind == tsep_pkg::CMD_DAC_PUSH) && !dac_full;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        spk_head_next  = spk_head_reg;
        spk_tail_next  = spk_tail_reg;
        spk_count_next = spk_count_reg;
        dac_head_next  = dac_head_reg;
        dac_tail_next  = dac_tail_reg;
        dac_count_next = dac_count_reg;
        tick_next      = tick_reg;
        dac_hold_next  = dac_hold_reg;
        pend_next      = pend_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_item_next  = res_item_reg;

        if (cfg_valid)
        begin
            mode_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    pend_next = '0;
                    unique case (head_cmd.kind)
                        tsep_pkg::CMD_SPK_PUSH:
                        begin
                            if (!spk_full)
                            begin
                                spk_tail_next = (spk_tail_reg ==
                                    tsep_pkg::SPK_AW'(tsep_pkg::SPK_DEPTH - 1))
                                    ? '0 : spk_tail_reg + 1'b1;
                                spk_count_next = spk_count_reg + 1'b1;
                                pend_next.accepted = 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        tsep_pkg::CMD_DAC_PUSH:
                        begin
                            if (!dac_full)
                            begin
                                dac_tail_next = (dac_tail_reg ==
                                    tsep_pkg::DAC_AW'(tsep_pkg::DAC_DEPTH - 1))
                                    ? '0 : dac_tail_reg + 1'b1;
                                dac_count_next = dac_count_reg + 1'b1;
                                pend_next.accepted = 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        tsep_pkg::CMD_TICK:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // head entry lands in the read register at this edge
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!mode_reg && spk_due)
                begin
                    spk_head_next = (spk_head_reg ==
                        tsep_pkg::SPK_AW'(tsep_pkg::SPK_DEPTH - 1))
                        ? '0 : spk_head_reg + 1'b1;
                    spk_count_next = spk_count_reg - 1'b1;
                    state_next     = ST_READ;
                end
                else if (mode_reg && dac_due)
                begin
                    dac_hold_next = dac_smp_rd_reg;
                    dac_head_next = (dac_head_reg ==
                        tsep_pkg::DAC_AW'(tsep_pkg::DAC_DEPTH - 1))
                        ? '0 : dac_head_reg + 1'b1;
                    dac_count_next = dac_count_reg - 1'b1;
                    state_next     = ST_READ;
                end
                else
                begin
                    // nothing more due: emit the sample and advance time
                    pend_next.accepted = 1'b1;
                    pend_next.is_audio = 1'b1;
                    if (mode_reg)
                    begin
                        pend_next.audio_sample = {dac_level, 8'h00};
                    end
                    else
                    begin
                        pend_next.audio_sample = spk_head_reg[0] ? tsep_pkg::SPK_HIGH
                                                                 : tsep_pkg::SPK_LOW;
                    end
                    tick_next  = tick_reg + 32'd1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    res_item_next  = pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            spk_head_reg  <= '0;
            spk_tail_reg  <= '0;
            spk_count_reg <= '0;
            dac_head_reg  <= '0;
            dac_tail_reg  <= '0;
            dac_count_reg <= '0;
            tick_reg      <= '0;
            dac_hold_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            spk_head_reg  <= spk_head_next;
            spk_tail_reg  <= spk_tail_next;
            spk_count_reg <= spk_count_next;
            dac_head_reg  <= dac_head_next;
            dac_tail_reg  <= dac_tail_next;
            dac_count_reg <= dac_count_next;
            tick_reg      <= tick_next;
            dac_hold_reg  <= dac_hold_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        res_item_reg <= res_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (spk_we)
        begin
            spk_mem[spk_tail_reg] <= head_cmd.stamp;
        end
        spk_rd_reg <= spk_mem[spk_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (dac_we)
        begin
            dac_time_mem[dac_tail_reg] <= head_cmd.stamp;
            dac_smp_mem[dac_tail_reg]  <= head_cmd.sample;
        end
        dac_time_rd_reg <= dac_time_mem[dac_head_reg];
        dac_smp_rd_reg  <= dac_smp_mem[dac_head_reg];
    end

`ifndef NO_ASSERTIONS
    a_spk_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        spk_count_reg <= tsep_pkg::SPK_CW'(tsep_pkg::SPK_DEPTH))
        else $error("speaker ring count beyond depth");

    a_dac_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dac_count_reg <= tsep_pkg::DAC_CW'(tsep_pkg::DAC_DEPTH))
        else $error("dac ring count beyond depth");

    a_tick_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_reg != $past(tick_reg)) |-> ($past(state_reg) == ST_CHECK))
        else $error("tick counter moved outside a tick");

    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |=> (res_valid_reg && $stable(res_item_reg)))
        else $error("stalled result dropped or changed");

    a_drain_selected_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && mode_reg) |=> $stable(spk_head_reg))
        else $error("speaker ring drained in dac mode");
`endif

endmodule

FILE: rtl/timed_sound_event_player.sv
// ----------------------------------------------------------------------------
// timed_sound_event_player: timestamped speaker and DAC event player
// Queues speaker toggles and DAC samples and plays one sample per tick.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  cmd     | in        | cmd_valid/cmd_stall  | in_item_t: action, sample_byte, event_time
//  res     | out       | res_valid/res_stall  | res_item_t: accepted, audio_sample, is_audio
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_data: output_mode
//
//  A push or an unused action runs IDLE then DONE in the engine; a tick runs
//  IDLE, READ, CHECK, DONE and repeats READ, CHECK per drained event (registered read).
//  A 4-entry command queue keeps taking items while the engine works, until it is full.
//  Reset clears pointers, counts, tick counter, held sample and output_mode;
//  ring contents need no clearing. A stalled result holds in its register.
// ----------------------------------------------------------------------------
module timed_sound_event_player
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  tsep_pkg::in_item_t  cmd_item,
    output logic                res_valid,
    input  logic                res_stall,
    output tsep_pkg::res_item_t res_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    tsep_pkg::cq_status_t cq_status;
    tsep_pkg::cmd_t       push_cmd;
    tsep_pkg::cmd_t       head_cmd;
    logic                 push;
    logic                 pop;

    tsep_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .cq_status (cq_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tsep_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (cq_status)
    );

    tsep_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cq_status (cq_status),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule
